[design/yuv2bgr_pkg.sv]
// shared types, constants and register codes for the yuv to bgr converter
`timescale 1ns / 1ps

package yuv2bgr_pkg;

    localparam int COEF_W    = 19;
    localparam int PIX_W     = 8;
    localparam int DIFF_W    = PIX_W + 1;
    localparam int PROD_W    = COEF_W + DIFF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 3;

    localparam logic [PIX_W-1:0] CHROMA_ZERO = 8'd128;

    // register indexes
    localparam logic [IDX_W-1:0] REG_LUMA_GAIN    = 3'd0;
    localparam logic [IDX_W-1:0] REG_LUMA_OFFSET  = 3'd1;
    localparam logic [IDX_W-1:0] REG_BLUE_FROM_U  = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_FROM_U = 3'd3;
    localparam logic [IDX_W-1:0] REG_GREEN_FROM_V = 3'd4;
    localparam logic [IDX_W-1:0] REG_RED_FROM_V   = 3'd5;

    // reset values
    localparam logic signed [COEF_W-1:0] RST_LUMA_GAIN    = 19'sd76309;
    localparam logic [PIX_W-1:0]         RST_LUMA_OFFSET  = 8'd16;
    localparam logic signed [COEF_W-1:0] RST_BLUE_FROM_U  = 19'sd132201;
    localparam logic signed [COEF_W-1:0] RST_GREEN_FROM_U = -19'sd25675;
    localparam logic signed [COEF_W-1:0] RST_GREEN_FROM_V = -19'sd53279;
    localparam logic signed [COEF_W-1:0] RST_RED_FROM_V   = 19'sd104597;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_out_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] luma_gain;
        logic [PIX_W-1:0]         luma_offset;
        logic signed [COEF_W-1:0] blue_from_u;
        logic signed [COEF_W-1:0] green_from_u;
        logic signed [COEF_W-1:0] green_from_v;
        logic signed [COEF_W-1:0] red_from_v;
    } coef_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] u;
        logic signed [DIFF_W-1:0] v;
    } diff_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] yterm;
        logic signed [PROD_W-1:0] b_u;
        logic signed [PROD_W-1:0] g_u;
        logic signed [PROD_W-1:0] g_v;
        logic signed [PROD_W-1:0] r_v;
    } prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] g;
        logic signed [SUM_W-1:0] r;
    } sum_t;

endpackage

[design/yuv2bgr_cfg.sv]
// configuration register file holding the conversion coefficients
`timescale 1ns / 1ps

module yuv2bgr_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [yuv2bgr_pkg::IDX_W-1:0]    cfg_index,
    input  logic [yuv2bgr_pkg::COEF_W-1:0]   cfg_data,
    output yuv2bgr_pkg::coef_t               coef
);

    yuv2bgr_pkg::coef_t coef_reg;
    yuv2bgr_pkg::coef_t coef_next;

    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                yuv2bgr_pkg::REG_LUMA_GAIN:    coef_next.luma_gain    = cfg_data;
                yuv2bgr_pkg::REG_LUMA_OFFSET:
                    coef_next.luma_offset = cfg_data[yuv2bgr_pkg::PIX_W-1:0];
                yuv2bgr_pkg::REG_BLUE_FROM_U:  coef_next.blue_from_u  = cfg_data;
                yuv2bgr_pkg::REG_GREEN_FROM_U: coef_next.green_from_u = cfg_data;
                yuv2bgr_pkg::REG_GREEN_FROM_V: coef_next.green_from_v = cfg_data;
                yuv2bgr_pkg::REG_RED_FROM_V:   coef_next.red_from_v   = cfg_data;
                default:                       coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.luma_gain    <= yuv2bgr_pkg::RST_LUMA_GAIN;
            coef_reg.luma_offset  <= yuv2bgr_pkg::RST_LUMA_OFFSET;
            coef_reg.blue_from_u  <= yuv2bgr_pkg::RST_BLUE_FROM_U;
            coef_reg.green_from_u <= yuv2bgr_pkg::RST_GREEN_FROM_U;
            coef_reg.green_from_v <= yuv2bgr_pkg::RST_GREEN_FROM_V;
            coef_reg.red_from_v   <= yuv2bgr_pkg::RST_RED_FROM_V;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

[design/yuv2bgr_prep.sv]
// stage 1: remove black level and chroma zero
`timescale 1ns / 1ps

module yuv2bgr_prep (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  yuv2bgr_pkg::pixel_in_t     up_data,
    input  logic [yuv2bgr_pkg::PIX_W-1:0] luma_offset,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output yuv2bgr_pkg::diff_t         dn_data
);

    logic                 valid_reg;
    yuv2bgr_pkg::diff_t   diff_reg;
    yuv2bgr_pkg::diff_t   diff_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = diff_reg;

    always_comb
    begin
        diff_next.y = $signed({1'b0, up_data.luma}) - $signed({1'b0, luma_offset});
        diff_next.u = $signed({1'b0, up_data.chroma_blue})
                    - $signed({1'b0, yuv2bgr_pkg::CHROMA_ZERO});
        diff_next.v = $signed({1'b0, up_data.chroma_red})
                    - $signed({1'b0, yuv2bgr_pkg::CHROMA_ZERO});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            diff_reg <= diff_next;
        end
    end

endmodule

[design/yuv2bgr_mult.sv]
// stage 2: five coefficient products
`timescale 1ns / 1ps

module yuv2bgr_mult (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  yuv2bgr_pkg::diff_t   up_data,
    input  yuv2bgr_pkg::coef_t   coef,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output yuv2bgr_pkg::prod_t   dn_data
);

    logic                 valid_reg;
    yuv2bgr_pkg::prod_t   prod_reg;
    yuv2bgr_pkg::prod_t   prod_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = prod_reg;

    // signed 19 x 9 products, operands sign extended to the product width
    always_comb
    begin
        prod_next.yterm = yuv2bgr_pkg::PROD_W'(coef.luma_gain)
                        * yuv2bgr_pkg::PROD_W'(up_data.y);
        prod_next.b_u   = yuv2bgr_pkg::PROD_W'(coef.blue_from_u)
                        * yuv2bgr_pkg::PROD_W'(up_data.u);
        prod_next.g_u   = yuv2bgr_pkg::PROD_W'(coef.green_from_u)
                        * yuv2bgr_pkg::PROD_W'(up_data.u);
        prod_next.g_v   = yuv2bgr_pkg::PROD_W'(coef.green_from_v)
                        * yuv2bgr_pkg::PROD_W'(up_data.v);
        prod_next.r_v   = yuv2bgr_pkg::PROD_W'(coef.red_from_v)
                        * yuv2bgr_pkg::PROD_W'(up_data.v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

[design/yuv2bgr_sum_clip.sv]
// stages 3 and 4: channel sums, then floor shift and saturation
`timescale 1ns / 1ps

module yuv2bgr_sum_clip (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  yuv2bgr_pkg::prod_t     up_data,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output yuv2bgr_pkg::pixel_out_t dn_data
);

    localparam int SHR_W = yuv2bgr_pkg::SUM_W - yuv2bgr_pkg::FRAC_BITS;

    logic                     sum_valid_reg;
    yuv2bgr_pkg::sum_t        sum_reg;
    yuv2bgr_pkg::sum_t        sum_next;
    logic                     sum_ready;
    logic                     out_valid_reg;
    yuv2bgr_pkg::pixel_out_t  out_reg;
    yuv2bgr_pkg::pixel_out_t  out_next;

    function automatic logic [yuv2bgr_pkg::PIX_W-1:0] clip8(
        input logic signed [yuv2bgr_pkg::SUM_W-1:0] s
    );
        logic signed [SHR_W-1:0] q;
        q = SHR_W'(s >>> yuv2bgr_pkg::FRAC_BITS);
        priority if (q[SHR_W-1])
            clip8 = '0;
        else if (q[SHR_W-2:yuv2bgr_pkg::PIX_W] != '0)
            clip8 = '1;
        else
            clip8 = q[yuv2bgr_pkg::PIX_W-1:0];
    endfunction

    assign sum_ready = !out_valid_reg || dn_ready;
    assign up_ready  = !sum_valid_reg || sum_ready;
    assign dn_valid  = out_valid_reg;
    assign dn_data   = out_reg;

    always_comb
    begin
        sum_next.b = yuv2bgr_pkg::SUM_W'(up_data.yterm) + yuv2bgr_pkg::SUM_W'(up_data.b_u);
        sum_next.g = yuv2bgr_pkg::SUM_W'(up_data.yterm) + yuv2bgr_pkg::SUM_W'(up_data.g_u)
                   + yuv2bgr_pkg::SUM_W'(up_data.g_v);
        sum_next.r = yuv2bgr_pkg::SUM_W'(up_data.yterm) + yuv2bgr_pkg::SUM_W'(up_data.r_v);
        out_next.blue  = clip8(sum_reg.b);
        out_next.green = clip8(sum_reg.g);
        out_next.red   = clip8(sum_reg.r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                sum_valid_reg <= up_valid;
            end
            if (sum_ready)
            begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            sum_reg <= sum_next;
        end
        if (sum_ready && sum_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

endmodule

[design/yuv_to_bgr_color_convert.sv]
// top level of the yuv to bgr pixel converter
// throughput: one pixel per cycle while the output is not stalled, set by the four register stages
//   (offset removal, products, sums, shift and saturation), each taking a beat a cycle
// a stall on the output holds every full stage; empty stages keep filling
// reset (rst_n low, asynchronous) empties the pipeline and loads the default coefficients
`timescale 1ns / 1ps

module yuv_to_bgr_color_convert (
    input  logic                               clk,
    input  logic                               rst_n,
    // pixel input channel
    input  logic                               pix_valid,
    output logic                               pix_stall,
    input  yuv2bgr_pkg::pixel_in_t             pix,
    // bgr output channel
    output logic                               bgr_valid,
    input  logic                               bgr_stall,
    output yuv2bgr_pkg::pixel_out_t            bgr,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [yuv2bgr_pkg::IDX_W-1:0]      cfg_index,
    input  logic [yuv2bgr_pkg::COEF_W-1:0]     cfg_data
);

    yuv2bgr_pkg::coef_t coef;

    // stage to stage handshake
    logic               prep_ready;
    logic               diff_valid;
    logic               mult_ready;
    yuv2bgr_pkg::diff_t diff;
    logic               prod_valid;
    logic               clip_ready;
    yuv2bgr_pkg::prod_t prod;

    // the user must change coefficients only while the pipeline is empty; the block does not enforce this
    yuv2bgr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // stage 1: signed differences y - offset, u - 128, v - 128
    yuv2bgr_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (pix_valid),
        .up_ready    (prep_ready),
        .up_data     (pix),
        .luma_offset (coef.luma_offset),
        .dn_valid    (diff_valid),
        .dn_ready    (mult_ready),
        .dn_data     (diff)
    );

    // stage 2: one 19 x 9 multiplier per term
    yuv2bgr_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (diff_valid),
        .up_ready (mult_ready),
        .up_data  (diff),
        .coef     (coef),
        .dn_valid (prod_valid),
        .dn_ready (clip_ready),
        .dn_data  (prod)
    );

    // stages 3 and 4: sums, floor shift by 16, clamp to 0..255
    yuv2bgr_sum_clip u_sum_clip (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prod_valid),
        .up_ready (clip_ready),
        .up_data  (prod),
        .dn_valid (bgr_valid),
        .dn_ready (!bgr_stall),
        .dn_data  (bgr)
    );

    assign pix_stall = !prep_ready;

endmodule

[bench/yuv_to_bgr_color_convert_check.sv]
// watches the pixel, bgr and register channels, predicts every bgr beat and compares it
`timescale 1ns / 1ps

module yuv_to_bgr_color_convert_check
    import yuv2bgr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    input  logic               pix_stall,
    input  pixel_in_t          pix,
    input  logic               bgr_valid,
    input  logic               bgr_stall,
    input  pixel_out_t         bgr,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [COEF_W-1:0]  cfg_data,
    output int                 failures,
    output int                 pending
);

    coef_t      coefs;
    pixel_out_t expected_bgr [$];

    // floor shift, then clamp to the 8-bit range
    function automatic logic [PIX_W-1:0] clamp_channel(input longint sum);
        longint level;
        level = sum >>> FRAC_BITS;
        if (level < 0)
            return '0;
        if (level > 255)
            return '1;
        return level[PIX_W-1:0];
    endfunction

    function automatic pixel_out_t convert_pixel(input pixel_in_t p, input coef_t c);
        longint     y;
        longint     u;
        longint     v;
        longint     yterm;
        pixel_out_t o;
        y     = longint'(p.luma) - longint'(c.luma_offset);
        u     = longint'(p.chroma_blue) - longint'(CHROMA_ZERO);
        v     = longint'(p.chroma_red) - longint'(CHROMA_ZERO);
        yterm = longint'($signed(c.luma_gain)) * y;
        o.blue  = clamp_channel(yterm + longint'($signed(c.blue_from_u)) * u);
        o.green = clamp_channel(yterm + longint'($signed(c.green_from_u)) * u
                                      + longint'($signed(c.green_from_v)) * v);
        o.red   = clamp_channel(yterm + longint'($signed(c.red_from_v)) * v);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_out_t want;
        if (!rst_n)
        begin
            coefs.luma_gain    = RST_LUMA_GAIN;
            coefs.luma_offset  = RST_LUMA_OFFSET;
            coefs.blue_from_u  = RST_BLUE_FROM_U;
            coefs.green_from_u = RST_GREEN_FROM_U;
            coefs.green_from_v = RST_GREEN_FROM_V;
            coefs.red_from_v   = RST_RED_FROM_V;
            expected_bgr.delete();
            failures = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                // indexes past the last register are dropped
                case (cfg_index)
                    REG_LUMA_GAIN:    coefs.luma_gain    = cfg_data;
                    REG_LUMA_OFFSET:  coefs.luma_offset  = cfg_data[PIX_W-1:0];
                    REG_BLUE_FROM_U:  coefs.blue_from_u  = cfg_data;
                    REG_GREEN_FROM_U: coefs.green_from_u = cfg_data;
                    REG_GREEN_FROM_V: coefs.green_from_v = cfg_data;
                    REG_RED_FROM_V:   coefs.red_from_v   = cfg_data;
                    default: ;
                endcase
            end
            if (pix_valid && !pix_stall)
                expected_bgr.push_back(convert_pixel(pix, coefs));
            if (bgr_valid && !bgr_stall)
            begin
                if (expected_bgr.size() == 0)
                begin
                    $error("bgr beat %h with no pixel outstanding", bgr);
                    failures++;
                end
                else
                begin
                    want = expected_bgr.pop_front();
                    if (bgr.blue !== want.blue)
                    begin
                        $error("blue: expected %0d, got %0d", want.blue, bgr.blue);
                        failures++;
                    end
                    if (bgr.green !== want.green)
                    begin
                        $error("green: expected %0d, got %0d", want.green, bgr.green);
                        failures++;
                    end
                    if (bgr.red !== want.red)
                    begin
                        $error("red: expected %0d, got %0d", want.red, bgr.red);
                        failures++;
                    end
                end
            end
            pending <= expected_bgr.size();
        end
    end

endmodule

[bench/yuv_to_bgr_color_convert_tb.sv]
// testbench top for the yuv to bgr converter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module yuv_to_bgr_color_convert_tb;
    import yuv2bgr_pkg::*;

    // longest receiver hold-off, long enough to back the pipeline up into the input
    localparam int HOLD_CYCLES  = 64;
    // cycles without any accepted beat before the run is declared hung
    localparam int STALL_LIMIT  = 1000;
    // settle time after the last bgr beat
    localparam int DRAIN_CYCLES = 8;

    // indexes past the register file, writes there must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    logic               clk;
    logic               rst_n;
    logic               pix_valid;
    logic               pix_stall;
    pixel_in_t          pix;
    logic               bgr_valid;
    logic               bgr_stall;
    pixel_out_t         bgr;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [COEF_W-1:0]  cfg_data;

    int failures;
    int pending;
    int quiet_cycles = 0;

    // random gaps on each side, and a request for one long receiver hold-off
    bit tx_gaps  = 1'b0;
    bit rx_gaps  = 1'b0;
    bit hold_req = 1'b0;

    // corner pixels run under the default coefficients
    pixel_in_t corner_pixels [0:17] = '{
        '{8'd0,   8'd0,   8'd0},      // all zero
        '{8'd255, 8'd255, 8'd255},    // all full scale
        '{8'd0,   8'd255, 8'd255},    // no luma, strongest chroma
        '{8'd255, 8'd0,   8'd0},      // full luma, weakest chroma
        '{8'd16,  8'd128, 8'd128},    // exact black level, neutral chroma
        '{8'd235, 8'd128, 8'd128},    // nominal white
        '{8'd15,  8'd128, 8'd128},    // just under black, negative sum floors down
        '{8'd255, 8'd128, 8'd128},    // luma overflow saturates high
        '{8'd128, 8'd0,   8'd128},    // each chroma at its two extremes
        '{8'd128, 8'd255, 8'd128},
        '{8'd128, 8'd128, 8'd0},
        '{8'd128, 8'd128, 8'd255},
        '{8'd17,  8'd127, 8'd129},    // small sums near zero, blue one below zero
        '{8'd100, 8'd90,  8'd200},    // 4:2:2 pair sharing one chroma
        '{8'd180, 8'd90,  8'd200},
        '{8'haa,  8'h55,  8'haa},     // alternating bit patterns
        '{8'h55,  8'haa,  8'h55},
        '{8'd16,  8'd255, 8'd0}       // opposite chroma extremes at black
    };

    yuv_to_bgr_color_convert dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .bgr_valid (bgr_valid),
        .bgr_stall (bgr_stall),
        .bgr       (bgr),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    yuv_to_bgr_color_convert_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .bgr_valid (bgr_valid),
        .bgr_stall (bgr_stall),
        .bgr       (bgr),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // hang detection: counts cycles in which no beat moves on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_valid && !pix_stall) || (bgr_valid && !bgr_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("** yuv_to_bgr_color_convert: FAILED **");
                $finish;
            end
        end
    end

    // bgr receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        bgr_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                bgr_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                bgr_stall <= 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 4) == 0)
            begin
                bgr_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                bgr_stall <= 1'b0;
            end
        end
    end

    // one pixel beat, with an optional idle burst in front of it
    task automatic send_pixel(input pixel_in_t p);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (pix_stall);
    endtask

    // sample value leaning toward the rails now and then
    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // mostly 4:2:2 pairs (two luma samples on one chroma pair), some lone pixels
    task automatic send_random_pixels(input int count);
        pixel_in_t p;
        int        sent;
        sent = 0;
        while (sent < count)
        begin
            p.luma        = pick_level();
            p.chroma_blue = pick_level();
            p.chroma_red  = pick_level();
            send_pixel(p);
            sent++;
            if (sent < count && $urandom_range(0, 9) < 6)
            begin
                p.luma = pick_level();
                send_pixel(p);
                sent++;
            end
        end
    endtask

    // stop offering pixels and wait until every bgr beat has come back
    task automatic drain();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // full register load; junk in the upper offset bits and writes to spare indexes
    task automatic load_coefficients(input coef_t c);
        write_register(REG_LUMA_GAIN, c.luma_gain);
        write_register(REG_LUMA_OFFSET, {(COEF_W-PIX_W)'($urandom), c.luma_offset});
        write_register(REG_BLUE_FROM_U, c.blue_from_u);
        write_register(REG_GREEN_FROM_U, c.green_from_u);
        write_register(REG_GREEN_FROM_V, c.green_from_v);
        write_register(REG_RED_FROM_V, c.red_from_v);
        write_register(REG_SPARE_LO, COEF_W'($urandom));
        write_register(REG_SPARE_HI, COEF_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // half the time anywhere in range, otherwise a moderate gain around zero
    function automatic logic signed [COEF_W-1:0] random_coef();
        if ($urandom_range(0, 1) == 0)
            return COEF_W'($urandom);
        return COEF_W'($urandom_range(0, 262143) - 131072);
    endfunction

    // main sequence
    initial
    begin
        coef_t c;
        rst_n     = 1'b0;
        pix_valid = 1'b0;
        pix       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners under the reset coefficients, back to back
        foreach (corner_pixels[i])
            send_pixel(corner_pixels[i]);
        drain();

        // random traffic with gaps on both sides
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        send_random_pixels(400);
        drain();

        // every coefficient at its top, highest black level
        c.luma_gain    = COEF_MAX;
        c.luma_offset  = '1;
        c.blue_from_u  = COEF_MAX;
        c.green_from_u = COEF_MAX;
        c.green_from_v = COEF_MAX;
        c.red_from_v   = COEF_MAX;
        load_coefficients(c);
        send_random_pixels(150);
        drain();

        // every coefficient at its bottom, zero black level
        c.luma_gain    = COEF_MIN;
        c.luma_offset  = '0;
        c.blue_from_u  = COEF_MIN;
        c.green_from_u = COEF_MIN;
        c.green_from_v = COEF_MIN;
        c.red_from_v   = COEF_MIN;
        load_coefficients(c);
        // sender keeps pushing through a long hold-off so the input backs up
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        send_random_pixels(150);
        tx_gaps = 1'b1;
        drain();

        // a few random coefficient sets
        repeat (3)
        begin
            c.luma_gain    = random_coef();
            c.luma_offset  = PIX_W'($urandom);
            c.blue_from_u  = random_coef();
            c.green_from_u = random_coef();
            c.green_from_v = random_coef();
            c.red_from_v   = random_coef();
            load_coefficients(c);
            send_random_pixels(150);
            drain();
        end

        // back to the standard coefficients, full rate with no gaps at the end
        c.luma_gain    = RST_LUMA_GAIN;
        c.luma_offset  = RST_LUMA_OFFSET;
        c.blue_from_u  = RST_BLUE_FROM_U;
        c.green_from_u = RST_GREEN_FROM_U;
        c.green_from_v = RST_GREEN_FROM_V;
        c.red_from_v   = RST_RED_FROM_V;
        load_coefficients(c);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_random_pixels(250);
        drain();

        // let any stray beat show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("** yuv_to_bgr_color_convert: PASSED **");
        else
            $display("** yuv_to_bgr_color_convert: FAILED **");
        $finish;
    end

endmodule
